[rtl/core/assert_macros.svh]
// Assertion macros included by frontier_cell_stencil.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define FCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define FCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fcs_pkg.sv]
// Types and constants of the frontier cell stencil.
package fcs_pkg;

    // Cell codes kept in the line stores and the window
    typedef logic [1:0] t_code;
    localparam t_code CODE_NONE = 2'b00;
    localparam t_code CODE_UNK  = 2'b01;
    localparam t_code CODE_CAND = 2'b10;

    // Occupancy values with a meaning of their own
    localparam logic signed [7:0] OCC_UNKNOWN  = -8'sd1;
    localparam logic signed [7:0] OCC_OCCUPIED = 8'sd100;

    // Configuration register indexes
    localparam int CFG_DW = 11;
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GRID_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_GRID_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_COST_LIMIT  = 2'd2;

    // Reset values of the registers
    localparam logic [CFG_DW-1:0] RST_GRID_WIDTH  = 11'd1024;
    localparam logic [CFG_DW-1:0] RST_GRID_HEIGHT = 11'd1024;
    localparam logic [6:0]        RST_COST_LIMIT  = 7'd80;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic signed [7:0] occupancy;
        logic signed [7:0] cell_cost;
        logic              flush;
    } t_in;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic       is_frontier;
        logic       last;
    } t_out;

endpackage

[rtl/core/frontier_cell_stencil.sv]
// Frontier cell stencil: 3x3 frontier test on a raster stream of map cells.
//
// Input channel (i_in_valid/o_in_ready, i_in_data): one map cell per
// transaction in raster order, then flush transactions after the frame.
// Output channel (o_out_valid/i_out_ready, o_out_data): zero or one result
// per input transaction; the result for a cell is produced by the input
// transaction that arrives one row length plus one items later, so software
// sends that many flush items after the frame until the result marked last.
// Throughput: one input transaction per cycle while o_in_ready is high, set
// by the single read port of each line store and one read-modify-write pass per item.
// Output path: the item triggering a result is registered with its line-store
// read, then judged against the window and written into the result queue,
// whose non-empty count drives o_out_valid.
// Reset (synchronous, active low): registers take their reset values, the
// frame position, window and result queue clear. The line stores are not
// cleared; entries outside the current map are masked by position.
// A stalled receiver fills a four-entry result queue; o_in_ready drops
// when the queue plus the item in flight could overflow it.
// Configuration: i_cfg_we writes register i_cfg_index; any valid write
// restarts the frame.
module frontier_cell_stencil
    import fcs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in                 i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out                o_out_data
);
    `include "assert_macros.svh"

    localparam int CW = $clog2(MAX_WIDTH);       // column index / line address
    localparam int EW = $clog2(MAX_WIDTH + 1);   // effective width
    localparam int RW = $clog2(MAX_HEIGHT + 2);  // row counter, reaches h+1

    typedef struct packed {
        logic          res;
        logic          last;
        logic          top;
        logic          bottom;
        logic          left;
        logic          right;
        t_code         code;
        logic [CW-1:0] addr;
        logic [9:0]    row;
        logic [9:0]    col;
    } t_s1;

    function automatic logic [EW-1:0] clamp_w(input logic [CFG_DW-1:0] v);
        if (v == '0) begin
            return EW'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            return EW'(MAX_WIDTH);
        end else begin
            return EW'(v);
        end
    endfunction

    function automatic logic [RW-1:0] clamp_h(input logic [CFG_DW-1:0] v);
        if (v == '0) begin
            return RW'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            return RW'(MAX_HEIGHT);
        end else begin
            return RW'(v);
        end
    endfunction

    // Configuration
    logic [EW-1:0] r_eff_w;
    logic [RW-1:0] r_eff_h;
    logic [6:0]    r_cost_limit;
    logic          cfg_hit;

    // Frame position of the next input item
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_in_col;

    // Line stores, read data and forwarding
    t_code         r_upper_line  [MAX_WIDTH];
    t_code         r_middle_line [MAX_WIDTH];
    t_code         r_up_rd;
    t_code         r_mid_rd;
    logic          r_fwd;
    t_code         r_fwd_up;
    t_code         r_fwd_mid;

    // Judgment stage
    logic          r_s1_valid;
    t_s1           r_s1;
    t_s1           n_s1;
    t_code         r_win_a [3];   // window column judged-1 after shift
    t_code         r_win_b [3];   // window column of the judged cell
    t_code         s1_up_v;
    t_code         s1_mid_v;
    logic          nb_unk;
    t_out          s1_out;

    // Result queue
    t_out                 r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_fifo_cnt;
    logic                 push;
    logic                 pop;

    // Input decode
    logic          in_acc;
    logic          take;
    logic          col_nz;
    logic [RW-1:0] jr;
    logic [CW-1:0] jc;
    logic [RW+9:0] jr_ext;
    logic [CW+9:0] jc_ext;
    logic [EW-1:0] col_next;
    logic          cost_ok;
    t_code         in_code;

    assign cfg_hit = i_cfg_we && (i_cfg_index == CFG_GRID_WIDTH ||
                                  i_cfg_index == CFG_GRID_HEIGHT ||
                                  i_cfg_index == CFG_COST_LIMIT);

    assign o_in_ready = (r_fifo_cnt + FIFO_CW'(r_s1_valid)) < FIFO_CW'(FIFO_DEPTH);
    assign in_acc     = i_in_valid && o_in_ready;
    // a flush at frame start is taken and dropped
    assign take       = in_acc && !(i_in_data.flush && r_in_row == '0 && r_in_col == '0);

    // Cell code of the incoming item; flushes and cells past the map are empty
    assign cost_ok = !i_in_data.cell_cost[7] && (i_in_data.cell_cost[6:0] <= r_cost_limit);

    always_comb begin
        in_code = CODE_NONE;
        if (!i_in_data.flush && r_in_row < r_eff_h) begin
            if (i_in_data.occupancy == OCC_UNKNOWN) begin
                in_code = CODE_UNK;
            end else if (i_in_data.occupancy != OCC_OCCUPIED && cost_ok) begin
                in_code = CODE_CAND;
            end
        end
    end

    // Position of the judged cell: one row and one cell behind the input
    assign col_nz   = r_in_col != '0;
    assign jr       = r_in_row - (col_nz ? RW'(1) : RW'(2));
    assign jc       = col_nz ? r_in_col - CW'(1) : CW'(r_eff_w - EW'(1));
    assign jr_ext   = {10'b0, jr};
    assign jc_ext   = {10'b0, jc};
    assign col_next = EW'(r_in_col) + EW'(1);

    always_comb begin
        n_s1.res    = (col_nz ? (r_in_row >= RW'(1)) : (r_in_row >= RW'(2))) &&
                      (jr < r_eff_h);
        n_s1.top    = jr == '0;
        n_s1.bottom = jr == r_eff_h - RW'(1);
        n_s1.left   = jc == '0;
        n_s1.right  = EW'(jc) == r_eff_w - EW'(1);
        n_s1.last   = n_s1.res && n_s1.bottom && n_s1.right;
        n_s1.code   = in_code;
        n_s1.addr   = r_in_col;
        n_s1.row    = jr_ext[9:0];
        n_s1.col    = jc_ext[9:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w      <= clamp_w(RST_GRID_WIDTH);
            r_eff_h      <= clamp_h(RST_GRID_HEIGHT);
            r_cost_limit <= RST_COST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_eff_w      <= clamp_w(i_cfg_data);
                CFG_GRID_HEIGHT: r_eff_h      <= clamp_h(i_cfg_data);
                CFG_COST_LIMIT:  r_cost_limit <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_in_row <= '0;
            r_in_col <= '0;
        end else if (take) begin
            if (n_s1.last) begin
                r_in_row <= '0;
                r_in_col <= '0;
            end else if (col_next >= r_eff_w) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + RW'(1);
            end else begin
                r_in_col <= r_in_col + CW'(1);
            end
        end
    end

    // Line stores: read at accept, written back in the next cycle
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_up_rd  <= r_upper_line[r_in_col];
            r_mid_rd <= r_middle_line[r_in_col];
        end
        if (r_s1_valid) begin
            r_upper_line[r_s1.addr]  <= s1_mid_v;
            r_middle_line[r_s1.addr] <= r_s1.code;
        end
    end

    // Write-back of the same entry at the read edge is missed by the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= take && r_s1_valid && r_s1.addr == r_in_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_up  <= s1_mid_v;
        r_fwd_mid <= r_s1.code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1 <= n_s1;
        end
    end

    assign s1_up_v  = r_fwd ? r_fwd_up  : r_up_rd;
    assign s1_mid_v = r_fwd ? r_fwd_mid : r_mid_rd;

    // Unknown neighbors, masked at the map border
    always_comb begin
        nb_unk = (!r_s1.top    && !r_s1.left  && r_win_a[0][0]) ||
                 (!r_s1.top                   && r_win_b[0][0]) ||
                 (!r_s1.top    && !r_s1.right && s1_up_v[0])    ||
                 (!r_s1.left                  && r_win_a[1][0]) ||
                 (!r_s1.right                 && s1_mid_v[0])   ||
                 (!r_s1.bottom && !r_s1.left  && r_win_a[2][0]) ||
                 (!r_s1.bottom                && r_win_b[2][0]) ||
                 (!r_s1.bottom && !r_s1.right && r_s1.code[0]);
        s1_out.row         = r_s1.row;
        s1_out.col         = r_s1.col;
        s1_out.is_frontier = r_win_b[1][1] && nb_unk;
        s1_out.last        = r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            for (int k = 0; k < 3; k++) begin
                r_win_a[k] <= CODE_NONE;
                r_win_b[k] <= CODE_NONE;
            end
        end else if (r_s1_valid) begin
            if (r_s1.last) begin
                for (int k = 0; k < 3; k++) begin
                    r_win_a[k] <= CODE_NONE;
                    r_win_b[k] <= CODE_NONE;
                end
            end else begin
                for (int k = 0; k < 3; k++) begin
                    r_win_a[k] <= r_win_b[k];
                end
                r_win_b[0] <= s1_up_v;
                r_win_b[1] <= s1_mid_v;
                r_win_b[2] <= r_s1.code;
            end
        end
    end

    // Result queue
    assign push        = r_s1_valid && r_s1.res;
    assign o_out_valid = r_fifo_cnt != '0;
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_data  = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= s1_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + FIFO_CW'(push) - FIFO_CW'(pop);
        end
    end

    `FCS_ASSERT_IMP(a_fifo_bound, i_clk, i_rst_n, 1'b1,
                    r_fifo_cnt <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")
    `FCS_ASSERT_IMP(a_fwd_live, i_clk, i_rst_n, r_fwd, r_s1_valid,
                    "forwarding without an item in flight")
    `FCS_ASSERT_NXT(a_last_restart, i_clk, i_rst_n, take && n_s1.last,
                    r_in_row == '0 && r_in_col == '0, "frame did not restart after last")

endmodule
